// ===== hdl/skt_pkg.sv =====
// skt_pkg: shared constants, codes and types of the sorted key table
// used by the controller, the datapath, the top level and the checker
package skt_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_FIND   = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_ZERO     = 3'd1;
    localparam logic [2:0] STAT_DUP      = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;
    localparam logic [2:0] STAT_RANGE    = 3'd5;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_search;
        logic search_done;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [31:0] key;
        logic [31:0] data;
        logic [31:0] order;
        logic [4:0]  count;
    } t_result;

endpackage

// ===== hdl/skt_ctrl.sv =====
// skt_ctrl: sequencer of the sorted key table
// depends on skt_pkg; drives the datapath through t_dp_cmd
module skt_ctrl
    import skt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (!i_status.need_search || i_status.search_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = (r_state == S_IDLE);
        o_cmd.load     = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.step     = (r_state == S_SEARCH) && i_status.need_search
                         && !i_status.search_done;
        o_cmd.finish   = (r_state == S_FINISH);
        o_cmd.out_load = (r_state == S_RESP) && i_status.out_free;
    end

endmodule

// ===== hdl/skt_datapath.sv =====
// skt_datapath: entry stores, bisection registers, result and output registers
// depends on skt_pkg; steered by skt_ctrl through t_dp_cmd
module skt_datapath
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [31:0]      r_key_s   [DEPTH];
    logic [31:0]      r_data_s  [DEPTH];
    logic [31:0]      r_order_s [DEPTH];
    logic [CNT_W-1:0] r_fill;
    logic [31:0]      r_next_order;

    logic [1:0]       r_func;
    logic [31:0]      r_key;
    logic [31:0]      r_data;
    logic [7:0]       r_pos;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;

    t_result          r_res;
    t_result          n_res;
    t_result          r_out;
    logic             r_out_valid;

    logic [CNT_W-1:0] w_mid;
    logic [IDX_W-1:0] w_rd_idx;
    logic [31:0]      w_rd_key;
    logic             w_hit;
    logic             w_pos_ok;
    logic             w_insert;
    logic             w_take_order;

    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rd_idx = !i_cmd.finish ? w_mid[IDX_W-1:0]
                    : (r_func == FN_READ) ? IDX_W'(r_pos) : r_lo[IDX_W-1:0];
    assign w_rd_key = r_key_s[w_rd_idx];
    assign w_hit    = (r_lo < r_fill) && (w_rd_key == r_key);
    assign w_pos_ok = (32'(r_pos) < 32'(r_fill));

    assign o_status.need_search = ((r_func == FN_INSERT) || (r_func == FN_FIND))
                                  && (r_key != 32'd0);
    assign o_status.search_done = (r_lo >= r_hi);
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    always_comb begin
        n_res        = '0;
        n_res.count  = 5'(r_fill);
        w_insert     = 1'b0;
        w_take_order = 1'b0;
        unique case (r_func)
            FN_INSERT: begin
                if (r_key == 32'd0) begin
                    n_res.status = STAT_ZERO;
                end else begin
                    w_take_order = i_cmd.finish;
                    n_res.order  = r_next_order;
                    if (w_hit) begin
                        n_res.status = STAT_DUP;
                        n_res.slot   = 5'(r_lo);
                    end else if (r_fill >= CNT_W'(DEPTH)) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        n_res.slot  = 5'(r_lo);
                        n_res.count = 5'(r_fill + 1'b1);
                        w_insert    = i_cmd.finish;
                    end
                end
            end
            FN_FIND: begin
                if (r_key == 32'd0) begin
                    n_res.status = STAT_ZERO;
                end else if (!w_hit) begin
                    n_res.status = STAT_NOTFOUND;
                end else begin
                    n_res.slot  = 5'(r_lo);
                    n_res.key   = w_rd_key;
                    n_res.data  = r_data_s[w_rd_idx];
                    n_res.order = r_order_s[w_rd_idx];
                end
            end
            FN_READ: begin
                if (!w_pos_ok) begin
                    n_res.status = STAT_RANGE;
                end else begin
                    n_res.slot  = 5'(r_pos);
                    n_res.key   = w_rd_key;
                    n_res.data  = r_data_s[w_rd_idx];
                    n_res.order = r_order_s[w_rd_idx];
                end
            end
            default: begin
                n_res.status = STAT_OK;
            end
        endcase
    end

    // insert: the entry at the slot and the entries above it move up one place
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == r_lo) begin
                    r_key_s[i]   <= r_key;
                    r_data_s[i]  <= r_data;
                    r_order_s[i] <= r_next_order;
                end
            end
            for (int i = 1; i < DEPTH; i++) begin
                if ((CNT_W'(i) > r_lo) && (CNT_W'(i) <= r_fill)) begin
                    r_key_s[i]   <= r_key_s[i-1];
                    r_data_s[i]  <= r_data_s[i-1];
                    r_order_s[i] <= r_order_s[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_next_order <= '0;
        end else begin
            if (w_insert) r_fill <= r_fill + 1'b1;
            if (w_take_order) r_next_order <= r_next_order + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_tuser;
            r_key  <= i_s_tdata[31:0];
            r_data <= i_s_tdata[63:32];
            r_pos  <= i_s_tdata[71:64];
            r_lo   <= '0;
            r_hi   <= r_fill;
        end else if (i_cmd.step) begin
            if (w_rd_key < r_key) begin
                r_lo <= w_mid + 1'b1;
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.finish) r_res <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.count, r_out.order, r_out.data, r_out.key,
                         r_out.slot, r_out.status};

endmodule

// ===== hdl/sorted_key_table_unit.sv =====
// sorted_key_table_unit: top level of the sorted key table
// depends on skt_pkg, skt_ctrl and skt_datapath
//
// a table of up to 16 entries (key, data word, insertion number) kept in
// ascending key order. each input beat is an insert, a find or a read at a
// position, selected by s_axis_tuser; each yields exactly one result beat
// carrying a status, the slot, the entry and the entry count.
// an item is taken only while the unit is idle; searches bisect over the
// filled entries, one compare of the key store per cycle.
// an insert or find makes at most ceil(log2(entry count + 1)) search steps
// (at most 5 at 16 entries), and a read or an item with a zero key makes
// none; the result is then registered in a finish state and moved to the
// output register in a response state, after which the unit is idle again.
// results sit in an output register: the next item is accepted and worked
// on while a result waits, and the unit holds only if a second result is
// ready before the first was taken. m_axis_tdata holds still while stalled.
// a synchronous reset empties the table and restarts insertion numbering
// at zero; it takes effect at once, with no clearing pass.
module sorted_key_table_unit
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // search_key[31:0], entry_data[63:32], position[71:64]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[2:0], slot[7:3], key_out[39:8], data_out[71:40],
    // order_out[103:72], entry_count[108:104], zero pad[111:109]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    skt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    skt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/skt_checker.sv =====
// skt_checker: port-level assertions for sorted_key_table_unit
// depends on skt_pkg; attached to the top level by the bind below
module skt_checker
    import skt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic w_unused;
    assign w_unused = ^{s_axis_tdata, s_axis_tuser};

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // nothing to deliver straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat after reset");

    // a full error only when the table holds every entry
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == STAT_FULL)
        |-> m_axis_tdata[108:104] == 5'(DEPTH))
        else $error("full status with spare entries");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);
